// ----- hdl/fvg_pkg.sv -----
// ----------------------------------------------------------------------------
// fvg_pkg
// Types, codes and helpers shared by the FAT volume geometry block.
// ----------------------------------------------------------------------------
package fvg_pkg;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLUS   = 2'd1;
    localparam logic [1:0] KIND_FATLOC = 2'd2;
    localparam logic [1:0] KIND_DECODE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_READ     = 3'd1;
    localparam logic [2:0] ST_FAT16    = 3'd2;
    localparam logic [2:0] ST_FAT32    = 3'd3;
    localparam logic [2:0] ST_NO_BOOT  = 3'd4;
    localparam logic [2:0] ST_FAT12    = 3'd5;
    localparam logic [2:0] ST_UNMOUNT  = 3'd6;

    localparam logic [1:0] VT_NONE  = 2'd0;
    localparam logic [1:0] VT_FAT16 = 2'd1;
    localparam logic [1:0] VT_FAT32 = 2'd2;

    localparam logic [7:0]  OP_JMP_SHORT = 8'hEB;
    localparam logic [7:0]  OP_JMP_NEAR  = 8'hE9;
    localparam logic [31:0] FAT12_LIMIT  = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT  = 32'd65525;
    localparam logic [27:0] END_OF_CHAIN = 28'hFFFFFFF;

    // boot record field selected by a byte position
    localparam logic [3:0] F_NONE    = 4'd0;
    localparam logic [3:0] F_JUMP    = 4'd1;
    localparam logic [3:0] F_SSIZE   = 4'd2;
    localparam logic [3:0] F_CSIZE   = 4'd3;
    localparam logic [3:0] F_RSVD    = 4'd4;
    localparam logic [3:0] F_COPIES  = 4'd5;
    localparam logic [3:0] F_ROOTENT = 4'd6;
    localparam logic [3:0] F_TOTS    = 4'd7;
    localparam logic [3:0] F_FATS    = 4'd8;
    localparam logic [3:0] F_TOTL    = 4'd9;
    localparam logic [3:0] F_FATL    = 4'd10;
    localparam logic [3:0] F_ROOTCL  = 4'd11;
    localparam logic [3:0] F_PART    = 4'd12;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [8:0]  byte_index;
        logic        last_byte;
        logic [27:0] cluster;
        logic [31:0] fat_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sector;
        logic [11:0] byte_offset;
        logic [27:0] next_cluster;
    } t_out_item;

    typedef struct packed {
        t_in_item   item;
        logic [3:0] field;
        logic [1:0] lane;
    } t_cmd;

    function automatic logic [5:0] classify(input logic [8:0] idx);
        logic [3:0] f;
        logic [8:0] base;
        begin
            f    = F_NONE;
            base = 9'd0;
            if (idx == 9'h000) begin
                f = F_JUMP;
            end else if (idx == 9'h00B || idx == 9'h00C) begin
                f = F_SSIZE;   base = 9'h00B;
            end else if (idx == 9'h00D) begin
                f = F_CSIZE;   base = 9'h00D;
            end else if (idx == 9'h00E || idx == 9'h00F) begin
                f = F_RSVD;    base = 9'h00E;
            end else if (idx == 9'h010) begin
                f = F_COPIES;  base = 9'h010;
            end else if (idx == 9'h011 || idx == 9'h012) begin
                f = F_ROOTENT; base = 9'h011;
            end else if (idx == 9'h013 || idx == 9'h014) begin
                f = F_TOTS;    base = 9'h013;
            end else if (idx == 9'h016 || idx == 9'h017) begin
                f = F_FATS;    base = 9'h016;
            end else if (idx >= 9'h020 && idx <= 9'h023) begin
                f = F_TOTL;    base = 9'h020;
            end else if (idx >= 9'h024 && idx <= 9'h027) begin
                f = F_FATL;    base = 9'h024;
            end else if (idx >= 9'h02C && idx <= 9'h02F) begin
                f = F_ROOTCL;  base = 9'h02C;
            end else if (idx >= 9'h1C6 && idx <= 9'h1C9) begin
                f = F_PART;    base = 9'h1C6;
            end
            classify = {f, 2'(idx - base)};
        end
    endfunction

    function automatic logic [31:0] put_byte(input logic [31:0] old, input logic [1:0] lane,
                                             input logic [7:0] v);
        logic [31:0] r;
        begin
            r = old;
            case (lane)
                2'd0:    r[7:0]   = v;
                2'd1:    r[15:8]  = v;
                2'd2:    r[23:16] = v;
                default: r[31:24] = v;
            endcase
            put_byte = r;
        end
    endfunction

endpackage

// ----- hdl/fat_volume_geometry_and_cluster_map.sv -----
// ----------------------------------------------------------------------------
// fat_volume_geometry_and_cluster_map
// Mounts a FAT16/FAT32 volume from streamed boot sector bytes and maps
// clusters to sectors and FAT entry locations.
//
//   channel | direction | handshake                | word
//   in      | input     | i_in_valid / o_in_ready   | i_in_item (t_in_item)
//   out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Sector bytes and decode queries: front register, then the back step.
// Cluster to sector: one multiply step, then one add step; the root directory
// (cluster 0) is answered directly.
// FAT location and mount evaluation run through the shared 1-bit-per-cycle
// divider in the back part.
// Reset is synchronous; all volume state clears to not mounted.
// A two-entry queue lets the input side keep taking words while the back
// part divides or waits on a stalled result.
// ----------------------------------------------------------------------------
module fat_volume_geometry_and_cluster_map import fvg_pkg::*; #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    logic w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    t_cmd w_f_cmd, w_q_cmd;

    fvg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_cmd_valid(w_f_valid), .i_cmd_ready(w_f_ready), .o_cmd(w_f_cmd)
    );

    fvg_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push_valid(w_f_valid), .o_push_ready(w_f_ready), .i_push(w_f_cmd),
        .o_pop_valid(w_q_valid), .i_pop_ready(w_q_ready), .o_pop(w_q_cmd)
    );

    fvg_back #(.SECTOR_BYTES(SECTOR_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_q_valid), .o_cmd_ready(w_q_ready), .i_cmd(w_q_cmd),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );
endmodule

// ----- hdl/fvg_front.sv -----
// ----------------------------------------------------------------------------
// fvg_front
// Input stage: registers each word and tags sector bytes with their field.
// ----------------------------------------------------------------------------
module fvg_front import fvg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);
    logic r_valid;
    t_cmd r_cmd;
    logic [5:0] w_cls;

    assign w_cls       = classify(i_in_item.byte_index);
    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_cmd.item  <= i_in_item;
            r_cmd.field <= (i_in_item.kind == KIND_BYTE) ? w_cls[5:2] : F_NONE;
            r_cmd.lane  <= w_cls[1:0];
        end
    end
endmodule

// ----- hdl/fvg_queue.sv -----
// ----------------------------------------------------------------------------
// fvg_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module fvg_queue import fvg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop
);
    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop        = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_mem[r_wr] <= i_push;
    end
endmodule

// ----- hdl/fvg_back.sv -----
// ----------------------------------------------------------------------------
// fvg_back
// Execution part: boot record capture, mount evaluation and cluster queries,
// with one shared bit-serial divider.
// ----------------------------------------------------------------------------
module fvg_back import fvg_pkg::*; #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DROOT = 4'd2;
    localparam logic [3:0] S_CALC  = 4'd3;
    localparam logic [3:0] S_DCNT  = 4'd4;
    localparam logic [3:0] S_MROOT = 4'd5;
    localparam logic [3:0] S_FROOT = 4'd6;
    localparam logic [3:0] S_MCLU  = 4'd7;
    localparam logic [3:0] S_FCLU  = 4'd8;
    localparam logic [3:0] S_DFAT  = 4'd9;
    localparam logic [15:0] MaxSector = 16'(SECTOR_BYTES);

    logic [3:0]  r_state;
    logic [7:0]  r_jump;
    logic        r_mbr;
    logic [31:0] r_rel;
    logic [15:0] r_ss;
    logic [7:0]  r_cs;
    logic [15:0] r_rsvd;
    logic [7:0]  r_copies;
    logic [15:0] r_rent;
    logic [15:0] r_fats;
    logic [31:0] r_fatl;
    logic [15:0] r_tots;
    logic [31:0] r_totl;
    logic [31:0] r_rootcl;
    logic [31:0] r_tstart;
    logic [31:0] r_dstart;
    logic [31:0] r_rss;
    logic [1:0]  r_vt;
    logic [31:0] r_fat_area;
    logic [31:0] r_root_secs;
    logic [31:0] r_prod;
    logic [27:0] r_clus;
    logic [31:0] r_quo;
    logic [16:0] r_rem;
    logic [15:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_ov;
    t_out_item   r_out;

    logic        w_free;
    logic        w_pop;
    t_in_item    w_it;
    logic [16:0] w_shift;
    logic        w_ge;
    logic [31:0] w_fatsz;
    logic [31:0] w_totsec;
    logic [31:0] w_data_sec;
    logic        w_jump_ok;
    logic        w_bad_geom;

    assign w_free      = !r_ov || i_out_ready;
    assign o_cmd_ready = (r_state == S_IDLE) && w_free;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_it        = i_cmd.item;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    assign w_shift    = {r_rem[15:0], r_quo[31]};
    assign w_ge       = (w_shift >= {1'b0, r_dvs});
    assign w_fatsz    = (r_fats != 16'd0) ? {16'd0, r_fats} : r_fatl;
    assign w_totsec   = (r_tots != 16'd0) ? {16'd0, r_tots} : r_totl;
    assign w_data_sec = w_totsec - ({16'd0, r_rsvd} + r_fat_area + r_root_secs);
    assign w_jump_ok  = (r_jump == OP_JMP_SHORT) || (r_jump == OP_JMP_NEAR);
    assign w_bad_geom = (r_ss == 16'd0) || (r_ss > MaxSector) || (r_cs == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_jump <= '0;   r_mbr <= 1'b0;  r_rel <= '0;
            r_ss <= '0;         r_cs <= '0;     r_rsvd <= '0;   r_copies <= '0;
            r_rent <= '0;       r_fats <= '0;   r_fatl <= '0;   r_tots <= '0;
            r_totl <= '0;       r_rootcl <= '0; r_tstart <= '0; r_dstart <= '0;
            r_rss <= '0;        r_vt <= VT_NONE; r_fat_area <= '0;
            r_root_secs <= '0;  r_prod <= '0;   r_clus <= '0;   r_quo <= '0;
            r_rem <= '0;        r_dvs <= '0;    r_cnt <= '0;    r_ov <= 1'b0;
            r_out <= '0;
        end else begin
            if (i_out_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_out <= '0;
                        r_clus <= w_it.cluster;
                        if (w_it.kind == KIND_BYTE) begin
                            r_vt <= VT_NONE;
                            case (i_cmd.field)
                                F_JUMP:    r_jump <= w_it.byte_value;
                                F_SSIZE:   r_ss <= 16'(put_byte({16'd0, r_ss}, i_cmd.lane,
                                                                w_it.byte_value));
                                F_CSIZE:   r_cs <= w_it.byte_value;
                                F_RSVD:    r_rsvd <= 16'(put_byte({16'd0, r_rsvd},
                                                        i_cmd.lane, w_it.byte_value));
                                F_COPIES:  r_copies <= w_it.byte_value;
                                F_ROOTENT: r_rent <= 16'(put_byte({16'd0, r_rent},
                                                        i_cmd.lane, w_it.byte_value));
                                F_TOTS:    r_tots <= 16'(put_byte({16'd0, r_tots},
                                                        i_cmd.lane, w_it.byte_value));
                                F_FATS:    r_fats <= 16'(put_byte({16'd0, r_fats},
                                                        i_cmd.lane, w_it.byte_value));
                                F_TOTL:    r_totl <= put_byte(r_totl, i_cmd.lane,
                                                              w_it.byte_value);
                                F_FATL:    r_fatl <= put_byte(r_fatl, i_cmd.lane,
                                                              w_it.byte_value);
                                F_ROOTCL:  r_rootcl <= put_byte(r_rootcl, i_cmd.lane,
                                                                w_it.byte_value);
                                F_PART: begin
                                    if (!r_mbr) r_rel <= put_byte(r_rel, i_cmd.lane,
                                                                  w_it.byte_value);
                                end
                                default: ;
                            endcase
                            if (w_it.last_byte) r_state <= S_CHECK;
                        end else if (r_vt == VT_NONE) begin
                            r_out.status <= ST_UNMOUNT;
                            r_ov <= 1'b1;
                        end else if (w_it.kind == KIND_CLUS) begin
                            if (w_it.cluster == 28'd0) begin
                                r_out.sector <= r_rss;
                                r_ov <= 1'b1;
                            end else begin
                                r_state <= S_MCLU;
                            end
                        end else if (w_it.kind == KIND_FATLOC) begin
                            // entry bytes over sector size
                            r_quo <= (r_vt == VT_FAT32) ? {2'd0, w_it.cluster, 2'd0}
                                                        : {3'd0, w_it.cluster, 1'b0};
                            r_rem <= '0;
                            r_dvs <= r_ss;
                            r_cnt <= 6'd32;
                            r_state <= S_DFAT;
                        end else begin
                            if (r_vt == VT_FAT32) begin
                                r_out.next_cluster <= w_it.fat_word[27:0];
                            end else if (w_it.fat_word[15:0] == 16'hFFFF) begin
                                r_out.next_cluster <= END_OF_CHAIN;
                            end else begin
                                r_out.next_cluster <= {12'd0, w_it.fat_word[15:0]};
                            end
                            r_ov <= 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (!w_jump_ok) begin
                        r_mbr <= !r_mbr;
                        r_out.status <= r_mbr ? ST_NO_BOOT : ST_READ;
                        r_out.sector <= r_mbr ? 32'd0 : r_rel;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        if (!r_mbr) r_rel <= '0;
                        r_mbr <= 1'b0;
                        if (w_bad_geom) begin
                            r_out.status <= ST_NO_BOOT;
                            r_ov <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_fat_area <= 32'(r_copies * w_fatsz);
                            r_quo <= {11'd0, r_rent, 5'd0} + {16'd0, r_ss - 16'd1};
                            r_rem <= '0;
                            r_dvs <= r_ss;
                            r_cnt <= 6'd32;
                            r_state <= S_DROOT;
                        end
                    end
                end
                S_DROOT, S_DCNT, S_DFAT: begin
                    if (r_cnt != 6'd0) begin
                        r_rem <= w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;
                        r_quo <= {r_quo[30:0], w_ge};
                        r_cnt <= r_cnt - 6'd1;
                    end else if (r_state == S_DROOT) begin
                        r_root_secs <= r_quo;
                        r_state <= S_CALC;
                    end else if (r_state == S_DFAT) begin
                        r_out.sector <= r_quo + r_tstart;
                        r_out.byte_offset <= r_rem[11:0];
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_quo < FAT12_LIMIT) begin
                        r_out.status <= ST_FAT12;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_quo < FAT16_LIMIT) begin
                        r_vt <= VT_FAT16;
                        r_rss <= r_tstart + r_fat_area;
                        r_out.status <= ST_FAT16;
                        r_out.sector <= r_tstart + r_fat_area;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_vt <= VT_FAT32;
                        r_state <= S_MROOT;
                    end
                end
                S_CALC: begin
                    r_tstart <= {16'd0, r_rsvd} + r_rel;
                    r_dstart <= {16'd0, r_rsvd} + r_rel + r_fat_area + r_root_secs;
                    r_quo <= w_data_sec;
                    r_rem <= '0;
                    r_dvs <= {8'd0, r_cs};
                    r_cnt <= 6'd32;
                    r_state <= S_DCNT;
                end
                S_MROOT: begin
                    r_prod <= 32'((r_rootcl - 32'd2) * r_cs);
                    r_state <= S_FROOT;
                end
                S_FROOT: begin
                    r_rss <= r_prod + r_dstart;
                    r_out.status <= ST_FAT32;
                    r_out.sector <= r_prod + r_dstart;
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_MCLU: begin
                    r_prod <= 32'(({4'd0, r_clus} - 32'd2) * r_cs);
                    r_state <= S_FCLU;
                end
                S_FCLU: begin
                    r_out.sector <= r_prod + r_dstart;
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_out_ready |=> r_ov)
        else $error("result dropped before it was taken");
    a_mount_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vt != VT_NONE) |-> (r_ss != 16'd0 && r_cs != 8'd0))
        else $error("mounted with zero sector or cluster size");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 6'd0) |-> (r_state == S_DROOT || r_state == S_DCNT || r_state == S_DFAT))
        else $error("divider running outside a divide step");
endmodule

// ----- bench/fat_volume_geometry_and_cluster_map_tb.sv -----
// ----------------------------------------------------------------------------
// fat_volume_geometry_and_cluster_map_tb
// Streams boot sectors and partition sectors into the FAT geometry block,
// then issues cluster, FAT location and FAT decode queries. Every result
// word is checked against an in-bench geometry predictor, with random gaps
// on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module fat_volume_geometry_and_cluster_map_tb;
    import fvg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SECTOR_BYTES = 512;
    localparam int CYCLE_LIMIT  = 1500000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    fat_volume_geometry_and_cluster_map #(.SECTOR_BYTES(SECTOR_BYTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item)
    );

    // predictor state
    logic [7:0]  g_jump;
    logic        g_mbr_done;
    logic [31:0] g_rel_sec;
    logic [15:0] g_ssize;
    logic [7:0]  g_csize;
    logic [15:0] g_rsvd;
    logic [7:0]  g_copies;
    logic [15:0] g_rootent;
    logic [15:0] g_fats;
    logic [31:0] g_fatl;
    logic [15:0] g_tots;
    logic [31:0] g_totl;
    logic [31:0] g_rootcl;
    logic [31:0] g_fat_start;
    logic [31:0] g_data_start;
    logic [31:0] g_root_sec;
    logic [1:0]  g_vtype;

    t_in_item  pending_words[$];
    t_out_item expected_results[$];
    int        fail_count;
    int        cycle_count;
    int        in_gap;
    bit        stim_done;
    bit        hold_off;

    function automatic logic [31:0] set_lane(logic [31:0] old, int lane, logic [7:0] v);
        logic [31:0] r;
        r = old;
        r[lane*8 +: 8] = v;
        return r;
    endfunction

    function automatic void capture_byte(logic [8:0] idx, logic [7:0] v);
        if (idx == 0) g_jump = v;
        else if (idx >= 9'h0B && idx <= 9'h0C)
            g_ssize = 16'(set_lane(32'(g_ssize), idx - 9'h0B, v));
        else if (idx == 9'h0D) g_csize = v;
        else if (idx >= 9'h0E && idx <= 9'h0F)
            g_rsvd = 16'(set_lane(32'(g_rsvd), idx - 9'h0E, v));
        else if (idx == 9'h10) g_copies = v;
        else if (idx >= 9'h11 && idx <= 9'h12)
            g_rootent = 16'(set_lane(32'(g_rootent), idx - 9'h11, v));
        else if (idx >= 9'h13 && idx <= 9'h14)
            g_tots = 16'(set_lane(32'(g_tots), idx - 9'h13, v));
        else if (idx >= 9'h16 && idx <= 9'h17)
            g_fats = 16'(set_lane(32'(g_fats), idx - 9'h16, v));
        else if (idx >= 9'h20 && idx <= 9'h23) g_totl = set_lane(g_totl, idx - 9'h20, v);
        else if (idx >= 9'h24 && idx <= 9'h27) g_fatl = set_lane(g_fatl, idx - 9'h24, v);
        else if (idx >= 9'h2C && idx <= 9'h2F) g_rootcl = set_lane(g_rootcl, idx - 9'h2C, v);
        else if (idx >= 9'h1C6 && idx <= 9'h1C9 && !g_mbr_done)
            g_rel_sec = set_lane(g_rel_sec, idx - 9'h1C6, v);
    endfunction

    function automatic void mount_volume(output logic [2:0] st, output logic [31:0] sec);
        logic [31:0] fatsz, totsec, root_secs, fat_area, data_sec, count;
        sec = 0;
        if (g_ssize == 0 || 32'(g_ssize) > SECTOR_BYTES || g_csize == 0) begin
            st = ST_NO_BOOT;
            return;
        end
        fatsz     = g_fats != 0 ? 32'(g_fats) : g_fatl;
        totsec    = g_tots != 0 ? 32'(g_tots) : g_totl;
        root_secs = (32'(g_rootent) * 32 + (32'(g_ssize) - 1)) / 32'(g_ssize);
        fat_area  = 32'(g_copies) * fatsz;
        data_sec  = totsec - (32'(g_rsvd) + fat_area + root_secs);
        g_fat_start  = 32'(g_rsvd) + g_rel_sec;
        g_data_start = g_fat_start + fat_area + root_secs;
        count = data_sec / 32'(g_csize);
        if (count < FAT12_LIMIT) begin
            st = ST_FAT12;
        end else if (count < FAT16_LIMIT) begin
            g_vtype    = VT_FAT16;
            g_root_sec = g_fat_start + fat_area;
            sec = g_root_sec;
            st  = ST_FAT16;
        end else begin
            g_vtype    = VT_FAT32;
            g_root_sec = (g_rootcl - 2) * 32'(g_csize) + g_data_start;
            sec = g_root_sec;
            st  = ST_FAT32;
        end
    endfunction

    // work out the result of one accepted word, if any
    function automatic void predict_geometry(t_in_item it);
        t_out_item   r;
        logic [31:0] bytes, dv, cl;
        r  = '0;
        cl = 32'(it.cluster);
        if (it.kind == KIND_BYTE) begin
            g_vtype = VT_NONE;
            capture_byte(it.byte_index, it.byte_value);
            if (!it.last_byte) return;
            if (g_jump != OP_JMP_SHORT && g_jump != OP_JMP_NEAR) begin
                if (!g_mbr_done) begin
                    g_mbr_done = 1;
                    r.status = ST_READ;
                    r.sector = g_rel_sec;
                end else begin
                    g_mbr_done = 0;
                    r.status = ST_NO_BOOT;
                end
            end else begin
                if (!g_mbr_done) g_rel_sec = 0;
                g_mbr_done = 0;
                mount_volume(r.status, r.sector);
            end
        end else if (g_vtype == VT_NONE) begin
            r.status = ST_UNMOUNT;
        end else begin
            r.status = ST_OK;
            if (it.kind == KIND_CLUS) begin
                r.sector = cl == 0 ? g_root_sec : (cl - 2) * 32'(g_csize) + g_data_start;
            end else if (it.kind == KIND_FATLOC) begin
                bytes = cl * (g_vtype == VT_FAT32 ? 32'd4 : 32'd2);
                dv = g_ssize != 0 ? 32'(g_ssize) : 32'd1;
                r.sector = bytes / dv + g_fat_start;
                r.byte_offset = 12'(bytes % dv);
            end else if (g_vtype == VT_FAT32) begin
                r.next_cluster = it.fat_word[27:0];
            end else begin
                r.next_cluster = 28'(it.fat_word[15:0]);
                if (it.fat_word[15:0] == 16'hFFFF) r.next_cluster = END_OF_CHAIN;
            end
        end
        expected_results.push_back(r);
    endfunction

    function automatic t_in_item byte_word(int idx, logic [7:0] v, bit last);
        t_in_item it;
        it = '0;
        it.kind = KIND_BYTE;
        it.byte_index = 9'(idx);
        it.byte_value = v;
        it.last_byte = last;
        it.cluster = 28'($urandom);
        it.fat_word = $urandom;
        return it;
    endfunction

    function automatic t_in_item query_word(logic [1:0] k, logic [27:0] cl, logic [31:0] w);
        t_in_item it;
        it = '0;
        it.kind = k;
        it.cluster = cl;
        it.fat_word = w;
        it.byte_value = 8'($urandom);
        it.byte_index = 9'($urandom);
        it.last_byte = 1'($urandom);
        return it;
    endfunction

    // queue the boot record fields in random order, a quarter of the time one field fewer, then the last byte
    task automatic send_boot(logic [7:0] jmp, logic [15:0] ssize, logic [7:0] csize,
                             logic [15:0] rsvd, logic [7:0] copies, logic [15:0] rootent,
                             logic [15:0] tots, logic [15:0] fats, logic [31:0] totl,
                             logic [31:0] fatl, logic [31:0] rootcl);
        logic [7:0] img [0:47];
        int order [$];
        int j;
        for (int i = 0; i < 48; i++) img[i] = 8'($urandom);
        img[0] = jmp;
        {img[12], img[11]} = ssize;
        img[13] = csize;
        {img[15], img[14]} = rsvd;
        img[16] = copies;
        {img[18], img[17]} = rootent;
        {img[20], img[19]} = tots;
        {img[23], img[22]} = fats;
        {img[35], img[34], img[33], img[32]} = totl;
        {img[39], img[38], img[37], img[36]} = fatl;
        {img[47], img[46], img[45], img[44]} = rootcl;
        order = {0, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 22, 23,
                 32, 33, 34, 35, 36, 37, 38, 39, 44, 45, 46, 47};
        order.shuffle();
        if ($urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, order.size() - 1);
            order.delete(j);
        end
        foreach (order[i]) pending_words.push_back(byte_word(order[i], img[order[i]], 0));
        pending_words.push_back(byte_word($urandom_range(48, 511), 8'($urandom), 1));
    endtask

    task automatic send_mbr(logic [31:0] lba);
        pending_words.push_back(byte_word(0, 8'($urandom_range(0, 1) ? 8'h00 : 8'h55), 0));
        for (int i = 0; i < 4; i++)
            pending_words.push_back(byte_word(9'h1C6 + i, lba[i*8 +: 8], 0));
        pending_words.push_back(byte_word(9'h1FE, 8'hAA, 1));
    endtask

    task automatic send_random_boot(bit fat32);
        logic [15:0] ss;
        logic [7:0]  cs;
        logic [15:0] rs;
        ss = 16'($urandom_range(0, 9) == 0 ? $urandom : (32'd1 << $urandom_range(0, 9)));
        cs = 8'($urandom_range(0, 9) == 0 ? $urandom : (32'd1 << $urandom_range(0, 7)));
        rs = 16'($urandom_range(1, 64));
        if (fat32)
            send_boot($urandom_range(0, 1) ? OP_JMP_SHORT : OP_JMP_NEAR, ss, cs, rs,
                      8'($urandom_range(1, 2)), 16'd0, 16'd0, 16'd0,
                      $urandom, $urandom_range(100, 100000), $urandom_range(2, 1000));
        else
            send_boot($urandom_range(0, 1) ? OP_JMP_SHORT : OP_JMP_NEAR, ss, cs, rs,
                      8'($urandom_range(1, 2)), 16'($urandom_range(0, 1024)),
                      16'($urandom), 16'($urandom_range(1, 256)), $urandom, $urandom,
                      $urandom);
    endtask

    task automatic send_queries(int n);
        logic [1:0]  k;
        logic [27:0] cl;
        for (int i = 0; i < n; i++) begin
            k = 2'($urandom_range(1, 3));
            case ($urandom_range(0, 3))
                0:       cl = 28'd0;
                1:       cl = 28'hFFFFFFF;
                default: cl = 28'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(2, 5000));
            endcase
            pending_words.push_back(query_word(k, cl,
                $urandom_range(0, 4) == 0 ? 32'h0000FFFF : $urandom));
        end
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus
    initial begin
        fail_count = 0;
        stim_done  = 0;
        i_rst_n    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: queries before mount, a mount, queries, the special cases
        pending_words.push_back(query_word(KIND_CLUS, 28'd5, 32'd0));
        pending_words.push_back(query_word(KIND_DECODE, 28'd0, 32'hFFFFFFFF));
        send_boot(OP_JMP_SHORT, 16'd512, 8'd4, 16'd1, 8'd2, 16'd512, 16'hFFFF, 16'd64,
                  32'd0, 32'd0, 32'd2);
        pending_words.push_back(query_word(KIND_CLUS, 28'd0, 32'd0));
        pending_words.push_back(query_word(KIND_FATLOC, 28'hFFFFFFF, 32'd0));
        pending_words.push_back(query_word(KIND_DECODE, 28'd0, 32'h1234FFFF));
        pending_words.push_back(query_word(KIND_DECODE, 28'd0, 32'hFFFF0000));
        send_mbr(32'hFFFFFFFF);
        send_boot(OP_JMP_NEAR, 16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0, 16'd0,
                  32'hFFFFFFFF, 32'd1000, 32'hFFFFFFFF);
        pending_words.push_back(query_word(KIND_DECODE, 28'd0, 32'hFFFFFFFF));
        pending_words.push_back(query_word(KIND_FATLOC, 28'd7, 32'd0));
        send_mbr(32'h00000800);
        send_mbr(32'h00000000);                 // second sector lacks a jump
        send_boot(OP_JMP_SHORT, 16'd0, 8'd1, 16'd1, 8'd1, 16'd0, 16'd100, 16'd1,
                  32'd0, 32'd0, 32'd0);         // zero sector size
        send_boot(OP_JMP_SHORT, 16'd1024, 8'd1, 16'd1, 8'd1, 16'd0, 16'd100, 16'd1,
                  32'd0, 32'd0, 32'd0);         // sector size too big
        send_boot(OP_JMP_SHORT, 16'd512, 8'd0, 16'd1, 8'd1, 16'd0, 16'd100, 16'd1,
                  32'd0, 32'd0, 32'd0);         // zero cluster size
        send_boot(OP_JMP_SHORT, 16'd512, 8'd1, 16'd1, 8'd1, 16'd16, 16'd2000, 16'd8,
                  32'd0, 32'd0, 32'd0);         // FAT12
        pending_words.push_back(query_word(KIND_CLUS, 28'd3, 32'd0));

        // random: mostly well-formed mounts followed by query bursts
        while (pending_words.size() < 800) begin
            case ($urandom_range(0, 9))
                0:       send_mbr($urandom);
                1: begin
                    pending_words.push_back(byte_word($urandom_range(0, 511),
                                                      8'($urandom), $urandom_range(0, 1)));
                end
                2, 3, 4: send_random_boot(1);
                default: begin
                    if ($urandom_range(0, 2) == 0) send_mbr($urandom_range(0, 1 << 20));
                    send_random_boot(0);
                end
            endcase
            send_queries($urandom_range(5, 25));
        end
        stim_done = 1;
    end

    // driver: mostly back-to-back words, some short gaps, now and then a long one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            i_in_item  <= '0;
            in_gap     <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) predict_geometry(i_in_item);
            if (pending_words.size() > 0 && in_gap == 0) begin
                i_in_valid <= 1;
                i_in_item  <= pending_words.pop_front();
                case ($urandom_range(0, 39))
                    0:                         in_gap <= $urandom_range(20, 80);
                    1, 2, 3, 4, 5, 6, 7, 8, 9: in_gap <= $urandom_range(1, 3);
                    default:                   in_gap <= 0;
                endcase
            end else begin
                i_in_valid <= 0;
                if (in_gap > 0) in_gap <= in_gap - 1;
            end
        end
    end

    // receiver pacing: random stalls plus one long hold-off
    initial begin
        i_out_ready = 0;
        hold_off    = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        repeat (300) begin
            @(posedge i_clk);
            i_out_ready <= $urandom_range(0, 1);
        end
        hold_off = 1;
        i_out_ready <= 0;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
        forever begin
            @(posedge i_clk);
            case ($urandom_range(0, 19))
                0: begin
                    i_out_ready <= 0;
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                end
                1, 2, 3: i_out_ready <= 0;
                default: i_out_ready <= 1;
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %p", o_out_item);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (o_out_item.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_out_item.status);
                    fail_count++;
                end
                if (o_out_item.sector !== e.sector) begin
                    $error("sector: expected %h, actual %h", e.sector, o_out_item.sector);
                    fail_count++;
                end
                if (o_out_item.byte_offset !== e.byte_offset) begin
                    $error("byte_offset: expected %h, actual %h", e.byte_offset,
                           o_out_item.byte_offset);
                    fail_count++;
                end
                if (o_out_item.next_cluster !== e.next_cluster) begin
                    $error("next_cluster: expected %h, actual %h", e.next_cluster,
                           o_out_item.next_cluster);
                    fail_count++;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
            if (stim_done && pending_words.size() == 0 && !i_in_valid
                && expected_results.size() == 0 && !hold_off) begin
                repeat (200) @(posedge i_clk);
                if (fail_count == 0 && expected_results.size() == 0)
                    $display("SUCCESS");
                else
                    $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
